// File: sv/dcfd_pkg.sv
// Shared types and constants for the display command frame decoder.
package dcfd_pkg;

    // One input request: a frame byte and its end marker.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_t;

    // One decoded frame.
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  command;
        logic [7:0]  param_value;
        logic [15:0] baud_word;
        logic [1:0]  text_start;
        logic [7:0]  text_count;
        logic [7:0]  payload_len;
    } out_t;

    // Frame summary handed from the front end to the decoder.
    typedef struct packed {
        logic [2:0] small_len;   // length, clamped at 7
        logic       too_long;    // length above the maximum
        logic [7:0] pay_len;     // length minus three, saturated
        logic [7:0] txt_len;     // length minus four, saturated
        logic [7:0] first_byte;
        logic [7:0] command_byte;
        logic [7:0] param_byte;
        logic [7:0] high_word_byte;
        logic [7:0] low_word_byte;
        logic [7:0] last_val;
    } frame_t;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] ROW_RESET = 4'd6;
    localparam logic [3:0] ROW_LIMIT = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FRAME = 2'd1;
    localparam logic [1:0] ST_CMD   = 2'd2;
    localparam logic [1:0] ST_PARAM = 2'd3;

    localparam logic [4:0] CMD_NONE     = 5'd0;
    localparam logic [4:0] CMD_INIT     = 5'd1;
    localparam logic [4:0] CMD_CHECK    = 5'd2;
    localparam logic [4:0] CMD_LINE     = 5'd3;
    localparam logic [4:0] CMD_SCREEN   = 5'd4;
    localparam logic [4:0] CMD_ERASE    = 5'd5;
    localparam logic [4:0] CMD_FIXED    = 5'd6;
    localparam logic [4:0] CMD_VOICE    = 5'd7;
    localparam logic [4:0] CMD_BRIGHT   = 5'd8;
    localparam logic [4:0] CMD_VOLUME   = 5'd9;
    localparam logic [4:0] CMD_COLOR    = 5'd10;
    localparam logic [4:0] CMD_BAUD     = 5'd11;
    localparam logic [4:0] CMD_DOT_SIZE = 5'd12;
    localparam logic [4:0] CMD_FONT     = 5'd13;
    localparam logic [4:0] CMD_PROTO    = 5'd14;
    localparam logic [4:0] CMD_FILL     = 5'd15;
    localparam logic [4:0] CMD_VERSION  = 5'd16;
    localparam logic [4:0] CMD_QUERY    = 5'd17;
    localparam logic [4:0] CMD_CLEAR    = 5'd18;

    localparam logic [7:0] HOST_START  = 8'h0A;
    localparam logic [7:0] HOST_CMD    = 8'h46;
    localparam logic [7:0] HOST_QUERY  = 8'h0A;
    localparam logic [7:0] HOST_CLEAR  = 8'h0D;
    localparam logic [7:0] BRACE_OPEN  = 8'h7B;
    localparam logic [7:0] BRACE_CLOSE = 8'h7D;
    localparam logic [7:0] RAW_BASE    = 8'h40;
    localparam logic [7:0] RAW_DUAL    = 8'h41;
    localparam logic [7:0] RAW_TOP     = 8'h45;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_ONE    = 8'h31;
    localparam logic [7:0] CHAR_THREE  = 8'h33;
    localparam logic [7:0] CHAR_FIVE   = 8'h35;
    localparam logic [7:0] CHAR_SEVEN  = 8'h37;
    localparam logic [7:0] CHAR_EIGHT  = 8'h38;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [15:0] BAUD_LOW   = 16'h2580;
    localparam logic [15:0] BAUD_HIGH  = 16'hC200;
    localparam logic [7:0] FIXED_MIN0  = 8'd11;
    localparam logic [7:0] FIXED_MIN1  = 8'd20;

endpackage

// File: sv/display_command_frame_decoder.sv
// Top level: display command frame decoder.
// Accepts one frame byte per cycle while the queue is not full, with no gaps between frames.
// out_valid rises once the decoder has loaded the frame's queued summary into the output register.
// Results leave at up to one per cycle; a two-entry queue before the output
// register lets the byte side keep going while the result side stalls.
// Reset clears the byte counter, captured bytes and queue; max_row_reg resets to 6.
module display_command_frame_decoder #(
    parameter int MAX_FRAME_LEN = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic [3:0]     cfg_data,
    input  logic           in_valid,
    output logic           in_stall,
    input  dcfd_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output dcfd_pkg::out_t out_data
);

    logic             push, full, q_valid, pop, in_fire;
    dcfd_pkg::frame_t push_data, q_data;

    assign in_stall = full;
    assign in_fire  = in_valid && !in_stall;

    dcfd_front #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_fire   (in_fire),
        .push      (push),
        .push_data (push_data)
    );

    dcfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop)
    );

    dcfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: sv/dcfd_front.sv
// Front end: byte counter, header byte capture and frame summary.
module dcfd_front #(
    parameter int MAX_FRAME_LEN = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dcfd_pkg::in_t   in_data,
    input  logic            in_fire,
    output logic            push,
    output dcfd_pkg::frame_t push_data
);

    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 2);
    localparam int EXT_W = CNT_W + 9;
    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_FRAME_LEN);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] param_reg, param_next;
    logic [7:0] high_reg, high_next;
    logic [7:0] low_reg, low_next;
    logic [CNT_W-1:0] len;
    logic [EXT_W-1:0] len_ext, diff3, diff4;
    logic [7:0] b;

    always_comb
    begin
        b = in_data.frame_byte;
        len = (count_reg <= MAX_LEN) ? count_reg + CNT_W'(1) : count_reg;
        first_next = (count_reg == CNT_W'(0)) ? b : first_reg;
        cmd_next   = (count_reg == CNT_W'(1)) ? b : cmd_reg;
        param_next = (count_reg == CNT_W'(2)) ? b : param_reg;
        high_next  = (count_reg == CNT_W'(3)) ? b : high_reg;
        low_next   = (count_reg == CNT_W'(4)) ? b : low_reg;
        count_next = len;

        len_ext = EXT_W'(len);
        diff3 = len_ext - EXT_W'(3);
        diff4 = len_ext - EXT_W'(4);

        push_data.small_len = (len > CNT_W'(7)) ? 3'd7 : len[2:0];
        push_data.too_long  = (len > MAX_LEN);
        push_data.pay_len   = (len_ext < EXT_W'(3)) ? 8'd0 :
                              (diff3 > EXT_W'(255)) ? 8'd255 : diff3[7:0];
        push_data.txt_len   = (len_ext < EXT_W'(4)) ? 8'd0 :
                              (diff4 > EXT_W'(255)) ? 8'd255 : diff4[7:0];
        push_data.first_byte     = first_next;
        push_data.command_byte   = cmd_next;
        push_data.param_byte     = param_next;
        push_data.high_word_byte = high_next;
        push_data.low_word_byte  = low_next;
        push_data.last_val       = b;
        push = in_fire && in_data.last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            first_reg <= '0;
            cmd_reg   <= '0;
            param_reg <= '0;
            high_reg  <= '0;
            low_reg   <= '0;
        end
        else if (in_fire)
        begin
            if (in_data.last_byte)
            begin
                count_reg <= '0;
                first_reg <= '0;
                cmd_reg   <= '0;
                param_reg <= '0;
                high_reg  <= '0;
                low_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                first_reg <= first_next;
                cmd_reg   <= cmd_next;
                param_reg <= param_next;
                high_reg  <= high_next;
                low_reg   <= low_next;
            end
        end
    end

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg == '0))
        else $error("byte count not cleared after frame end");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_LEN + CNT_W'(1))
        else $error("byte count past saturation");

endmodule

// File: sv/dcfd_queue.sv
// Two-entry queue of frame summaries between front end and decoder.
module dcfd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dcfd_pkg::frame_t push_data,
    output logic             full,
    output logic             q_valid,
    output dcfd_pkg::frame_t q_data,
    input  logic             pop
);

    localparam int PTR_W = $clog2(dcfd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dcfd_pkg::QUEUE_DEPTH + 1);

    dcfd_pkg::frame_t mem [dcfd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(dcfd_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(dcfd_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(dcfd_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue read while empty");

endmodule

// File: sv/dcfd_back.sv
// Decoder: turns a frame summary into a result and holds it for the output.
module dcfd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [3:0]       cfg_data,
    input  logic             q_valid,
    input  dcfd_pkg::frame_t q_data,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output dcfd_pkg::out_t   out_data
);

    logic [3:0] max_row_reg;
    logic       out_valid_reg;
    dcfd_pkg::out_t out_reg, res;
    logic [4:0] code;
    logic [3:0] row_max;
    logic [7:0] p, digit;
    logic [2:0] sl;

    function automatic logic [4:0] code_of(input logic [7:0] c);
        logic [4:0] v;
        if (c >= dcfd_pkg::CHAR_ONE && c <= dcfd_pkg::CHAR_NINE)
            v = 5'(c - dcfd_pkg::CHAR_ZERO);
        else if (c == dcfd_pkg::RAW_DUAL)
            v = dcfd_pkg::CMD_COLOR;
        else if (c >= dcfd_pkg::RAW_BASE && c <= dcfd_pkg::RAW_TOP)
            v = dcfd_pkg::CMD_BAUD + 5'(c - dcfd_pkg::RAW_BASE);
        else
            v = dcfd_pkg::CMD_NONE;
        return v;
    endfunction

    always_comb
    begin
        res = '0;
        p = q_data.param_byte;
        digit = p - dcfd_pkg::CHAR_ZERO;
        sl = q_data.small_len;
        code = code_of(q_data.command_byte);
        row_max = (max_row_reg > dcfd_pkg::ROW_LIMIT) ? dcfd_pkg::ROW_LIMIT : max_row_reg;

        if (sl < 3'd3 || q_data.too_long)
        begin
            res.status = dcfd_pkg::ST_FRAME;
        end
        else if (q_data.first_byte == dcfd_pkg::HOST_START)
        begin
            if (sl != 3'd3)
                res.status = dcfd_pkg::ST_FRAME;
            else if (q_data.command_byte == dcfd_pkg::HOST_CMD && p == dcfd_pkg::HOST_QUERY)
                res.command = dcfd_pkg::CMD_QUERY;
            else if (q_data.command_byte == dcfd_pkg::HOST_CMD && p == dcfd_pkg::HOST_CLEAR)
                res.command = dcfd_pkg::CMD_CLEAR;
            else
                res.status = dcfd_pkg::ST_CMD;
        end
        else if (q_data.first_byte != dcfd_pkg::BRACE_OPEN ||
                 q_data.last_val != dcfd_pkg::BRACE_CLOSE)
        begin
            res.status = dcfd_pkg::ST_FRAME;
        end
        else if (code == dcfd_pkg::CMD_NONE)
        begin
            res.status = dcfd_pkg::ST_CMD;
        end
        else
        begin
            res.command = code;
            res.payload_len = q_data.pay_len;
            if (q_data.command_byte == dcfd_pkg::RAW_DUAL)
            begin
                // 0x41 means dot size in a 4-byte frame, color in a 5-byte one
                if (sl == 3'd4)
                begin
                    res.command = dcfd_pkg::CMD_DOT_SIZE;
                    res.param_value = p;
                    res.status = (p <= 8'd2) ? dcfd_pkg::ST_OK : dcfd_pkg::ST_PARAM;
                end
                else if (sl == 3'd5)
                begin
                    res.param_value = digit;
                    res.status = (p >= dcfd_pkg::CHAR_ONE && p <= dcfd_pkg::CHAR_THREE) ?
                                 dcfd_pkg::ST_OK : dcfd_pkg::ST_PARAM;
                end
                else
                begin
                    res.status = dcfd_pkg::ST_FRAME;
                end
            end
            else
            begin
                unique case (code)
                    dcfd_pkg::CMD_BAUD:
                    begin
                        if (sl != 3'd6)
                            res.status = dcfd_pkg::ST_FRAME;
                        else
                        begin
                            res.param_value = p;
                            res.baud_word = {q_data.high_word_byte, q_data.low_word_byte};
                            res.status = (p > 8'd1 ||
                                          (res.baud_word != dcfd_pkg::BAUD_LOW &&
                                           res.baud_word != dcfd_pkg::BAUD_HIGH)) ?
                                         dcfd_pkg::ST_PARAM : dcfd_pkg::ST_OK;
                        end
                    end
                    dcfd_pkg::CMD_FONT, dcfd_pkg::CMD_PROTO, dcfd_pkg::CMD_FILL:
                    begin
                        if (sl != 3'd4)
                            res.status = dcfd_pkg::ST_FRAME;
                        else
                        begin
                            res.param_value = p;
                            res.status = (p <= ((code == dcfd_pkg::CMD_FONT) ? 8'd3 : 8'd2)) ?
                                         dcfd_pkg::ST_OK : dcfd_pkg::ST_PARAM;
                        end
                    end
                    dcfd_pkg::CMD_VERSION:
                    begin
                        res.status = (sl == 3'd3) ? dcfd_pkg::ST_OK : dcfd_pkg::ST_FRAME;
                    end
                    dcfd_pkg::CMD_INIT, dcfd_pkg::CMD_CHECK, dcfd_pkg::CMD_ERASE:
                    begin
                        res.status = (sl == 3'd3 || sl == 3'd4) ?
                                     dcfd_pkg::ST_OK : dcfd_pkg::ST_PARAM;
                    end
                    dcfd_pkg::CMD_LINE:
                    begin
                        if (sl < 3'd4 || p < dcfd_pkg::CHAR_ONE ||
                            p > dcfd_pkg::CHAR_ZERO + {4'd0, row_max})
                            res.status = dcfd_pkg::ST_PARAM;
                        else
                        begin
                            res.param_value = p - dcfd_pkg::CHAR_ONE;
                            res.text_start = 2'd3;
                            res.text_count = q_data.txt_len;
                        end
                    end
                    dcfd_pkg::CMD_SCREEN:
                    begin
                        res.text_start = 2'd2;
                        res.text_count = q_data.pay_len;
                    end
                    dcfd_pkg::CMD_FIXED:
                    begin
                        if (sl < 3'd4)
                            res.status = dcfd_pkg::ST_PARAM;
                        else
                        begin
                            res.param_value = digit;
                            if (digit > 8'd1)
                                res.status = dcfd_pkg::ST_PARAM;
                            else
                            begin
                                res.text_start = 2'd3;
                                res.text_count = q_data.txt_len;
                                res.status = (q_data.txt_len < ((digit == 8'd0) ?
                                              dcfd_pkg::FIXED_MIN0 : dcfd_pkg::FIXED_MIN1)) ?
                                             dcfd_pkg::ST_PARAM : dcfd_pkg::ST_OK;
                            end
                        end
                    end
                    dcfd_pkg::CMD_VOICE:
                    begin
                        if (sl < 3'd4)
                            res.status = dcfd_pkg::ST_PARAM;
                        else if (p >= dcfd_pkg::CHAR_ZERO && p <= dcfd_pkg::CHAR_SEVEN)
                            res.param_value = digit;
                        else if (p == dcfd_pkg::CHAR_EIGHT)
                        begin
                            // voice 8 carries text to speak
                            res.param_value = 8'd8;
                            res.text_start = 2'd3;
                            res.text_count = q_data.txt_len;
                            res.status = (sl > 3'd4) ? dcfd_pkg::ST_OK : dcfd_pkg::ST_PARAM;
                        end
                        else
                            res.status = dcfd_pkg::ST_PARAM;
                    end
                    dcfd_pkg::CMD_BRIGHT:
                    begin
                        if (sl < 3'd4)
                            res.status = dcfd_pkg::ST_PARAM;
                        else if (p <= 8'd8)
                            res.param_value = p;
                        else if (p >= dcfd_pkg::CHAR_ZERO && p <= dcfd_pkg::CHAR_EIGHT)
                            res.param_value = digit;
                        else
                            res.status = dcfd_pkg::ST_PARAM;
                    end
                    dcfd_pkg::CMD_VOLUME:
                    begin
                        if (sl < 3'd4)
                            res.status = dcfd_pkg::ST_PARAM;
                        else
                        begin
                            res.param_value = digit;
                            res.status = (p >= dcfd_pkg::CHAR_ONE && p <= dcfd_pkg::CHAR_FIVE) ?
                                         dcfd_pkg::ST_OK : dcfd_pkg::ST_PARAM;
                        end
                    end
                    default:
                    begin
                        res.status = dcfd_pkg::ST_CMD;
                    end
                endcase
            end
        end
    end

    assign pop       = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            max_row_reg   <= dcfd_pkg::ROW_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                max_row_reg <= cfg_data;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("decoded request not presented");

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the display command frame decoder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 14;

    // Tracks the frame in flight, predicts the decoded result on the last byte
    // and checks the block's results in order.
    class frame_result_board;
        logic [8:0] byte_total;
        logic [7:0] head_byte;
        logic [7:0] op_byte;
        logic [7:0] arg_byte;
        logic [7:0] word_hi;
        logic [7:0] word_lo;
        logic [3:0] row_limit;
        dcfd_pkg::out_t expected_frames[$];
        int errors;

        function new();
            clear_frame();
            row_limit = dcfd_pkg::ROW_RESET;
            errors = 0;
        endfunction

        function void clear_frame();
            byte_total = '0;
            head_byte = '0;
            op_byte = '0;
            arg_byte = '0;
            word_hi = '0;
            word_lo = '0;
        endfunction

        function void set_row(logic [3:0] value);
            row_limit = value;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function logic [7:0] clamp8(int unsigned x);
            return (x > 255) ? 8'd255 : 8'(x);
        endfunction

        function dcfd_pkg::out_t decode_frame(int unsigned len, logic [7:0] tail);
            dcfd_pkg::out_t r;
            logic [4:0] code;
            logic [7:0] digit;
            int unsigned rows;
            r = '0;
            digit = arg_byte - dcfd_pkg::CHAR_ZERO;
            if (len < 3 || len > MAX_LEN)
            begin
                r.status = dcfd_pkg::ST_FRAME;
                return r;
            end
            if (head_byte == dcfd_pkg::HOST_START)
            begin
                if (len != 3)
                    r.status = dcfd_pkg::ST_FRAME;
                else if (op_byte == dcfd_pkg::HOST_CMD && arg_byte == dcfd_pkg::HOST_QUERY)
                    r.command = dcfd_pkg::CMD_QUERY;
                else if (op_byte == dcfd_pkg::HOST_CMD && arg_byte == dcfd_pkg::HOST_CLEAR)
                    r.command = dcfd_pkg::CMD_CLEAR;
                else
                    r.status = dcfd_pkg::ST_CMD;
                return r;
            end
            if (head_byte != dcfd_pkg::BRACE_OPEN || tail != dcfd_pkg::BRACE_CLOSE)
            begin
                r.status = dcfd_pkg::ST_FRAME;
                return r;
            end
            // 0x41 doubles as 'A', so it is matched before the raw range
            if (op_byte >= dcfd_pkg::CHAR_ONE && op_byte <= dcfd_pkg::CHAR_NINE)
                code = 5'(op_byte - dcfd_pkg::CHAR_ZERO);
            else if (op_byte == dcfd_pkg::RAW_DUAL)
                code = dcfd_pkg::CMD_COLOR;
            else if (op_byte >= dcfd_pkg::RAW_BASE && op_byte <= dcfd_pkg::RAW_TOP)
                code = 5'(op_byte - dcfd_pkg::RAW_BASE) + dcfd_pkg::CMD_BAUD;
            else
            begin
                r.status = dcfd_pkg::ST_CMD;
                return r;
            end
            r.command = code;
            r.payload_len = clamp8(len - 3);
            if (code == dcfd_pkg::CMD_COLOR)
            begin
                if (len == 4)
                begin
                    r.command = dcfd_pkg::CMD_DOT_SIZE;
                    r.param_value = arg_byte;
                    r.status = (arg_byte <= 2) ? dcfd_pkg::ST_OK : dcfd_pkg::ST_PARAM;
                end
                else if (len == 5)
                begin
                    r.param_value = digit;
                    r.status = (arg_byte >= dcfd_pkg::CHAR_ONE &&
                                arg_byte <= dcfd_pkg::CHAR_THREE) ?
                               dcfd_pkg::ST_OK : dcfd_pkg::ST_PARAM;
                end
                else
                    r.status = dcfd_pkg::ST_FRAME;
                return r;
            end
            case (code)
                dcfd_pkg::CMD_BAUD:
                begin
                    if (len != 6)
                        r.status = dcfd_pkg::ST_FRAME;
                    else
                    begin
                        r.param_value = arg_byte;
                        r.baud_word = {word_hi, word_lo};
                        r.status = (arg_byte > 1 || (r.baud_word != dcfd_pkg::BAUD_LOW &&
                                   r.baud_word != dcfd_pkg::BAUD_HIGH)) ?
                                   dcfd_pkg::ST_PARAM : dcfd_pkg::ST_OK;
                    end
                end
                dcfd_pkg::CMD_FONT, dcfd_pkg::CMD_PROTO, dcfd_pkg::CMD_FILL:
                begin
                    if (len != 4)
                        r.status = dcfd_pkg::ST_FRAME;
                    else
                    begin
                        r.param_value = arg_byte;
                        r.status = (arg_byte <= ((code == dcfd_pkg::CMD_FONT) ? 3 : 2)) ?
                                   dcfd_pkg::ST_OK : dcfd_pkg::ST_PARAM;
                    end
                end
                dcfd_pkg::CMD_VERSION:
                    r.status = (len == 3) ? dcfd_pkg::ST_OK : dcfd_pkg::ST_FRAME;
                dcfd_pkg::CMD_INIT, dcfd_pkg::CMD_CHECK, dcfd_pkg::CMD_ERASE:
                    r.status = (len == 3 || len == 4) ? dcfd_pkg::ST_OK : dcfd_pkg::ST_PARAM;
                dcfd_pkg::CMD_LINE:
                begin
                    rows = (row_limit > dcfd_pkg::ROW_LIMIT) ? dcfd_pkg::ROW_LIMIT : row_limit;
                    if (len < 4 || arg_byte < dcfd_pkg::CHAR_ONE ||
                        arg_byte > dcfd_pkg::CHAR_ZERO + rows)
                        r.status = dcfd_pkg::ST_PARAM;
                    else
                    begin
                        r.param_value = arg_byte - dcfd_pkg::CHAR_ONE;
                        r.text_start = 2'd3;
                        r.text_count = clamp8(len - 4);
                    end
                end
                dcfd_pkg::CMD_SCREEN:
                begin
                    r.text_start = 2'd2;
                    r.text_count = clamp8(len - 3);
                end
                dcfd_pkg::CMD_FIXED:
                begin
                    if (len < 4)
                        r.status = dcfd_pkg::ST_PARAM;
                    else
                    begin
                        r.param_value = digit;
                        if (digit > 1)
                            r.status = dcfd_pkg::ST_PARAM;
                        else
                        begin
                            r.text_start = 2'd3;
                            r.text_count = clamp8(len - 4);
                            r.status = (len - 4 < ((digit == 0) ? dcfd_pkg::FIXED_MIN0 :
                                                   dcfd_pkg::FIXED_MIN1)) ?
                                       dcfd_pkg::ST_PARAM : dcfd_pkg::ST_OK;
                        end
                    end
                end
                dcfd_pkg::CMD_VOICE:
                begin
                    if (len < 4)
                        r.status = dcfd_pkg::ST_PARAM;
                    else if (arg_byte >= dcfd_pkg::CHAR_ZERO && arg_byte <= dcfd_pkg::CHAR_SEVEN)
                        r.param_value = digit;
                    else if (arg_byte == dcfd_pkg::CHAR_EIGHT)
                    begin
                        // voice index 8 carries text after it
                        r.param_value = 8'd8;
                        r.text_start = 2'd3;
                        r.text_count = clamp8(len - 4);
                        r.status = (len > 4) ? dcfd_pkg::ST_OK : dcfd_pkg::ST_PARAM;
                    end
                    else
                        r.status = dcfd_pkg::ST_PARAM;
                end
                dcfd_pkg::CMD_BRIGHT:
                begin
                    if (len < 4)
                        r.status = dcfd_pkg::ST_PARAM;
                    else if (arg_byte <= 8)
                        r.param_value = arg_byte;
                    else if (arg_byte >= dcfd_pkg::CHAR_ZERO && arg_byte <= dcfd_pkg::CHAR_EIGHT)
                        r.param_value = digit;
                    else
                        r.status = dcfd_pkg::ST_PARAM;
                end
                dcfd_pkg::CMD_VOLUME:
                begin
                    if (len < 4)
                        r.status = dcfd_pkg::ST_PARAM;
                    else
                    begin
                        r.param_value = digit;
                        r.status = (arg_byte >= dcfd_pkg::CHAR_ONE &&
                                    arg_byte <= dcfd_pkg::CHAR_FIVE) ?
                                   dcfd_pkg::ST_OK : dcfd_pkg::ST_PARAM;
                    end
                end
                default:
                    r.status = dcfd_pkg::ST_CMD;
            endcase
            return r;
        endfunction

        function void note_request(dcfd_pkg::in_t req);
            case (byte_total)
                9'd0: head_byte = req.frame_byte;
                9'd1: op_byte = req.frame_byte;
                9'd2: arg_byte = req.frame_byte;
                9'd3: word_hi = req.frame_byte;
                9'd4: word_lo = req.frame_byte;
                default: ;
            endcase
            if (byte_total <= MAX_LEN)
                byte_total++;
            if (req.last_byte)
            begin
                expected_frames.push_back(decode_frame(byte_total, req.frame_byte));
                clear_frame();
            end
        endfunction

        function void check_frame(dcfd_pkg::out_t got);
            dcfd_pkg::out_t want;
            if (expected_frames.size() == 0)
            begin
                $error("unexpected result %h with no frame pending", got);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            if (got.status !== want.status)
            begin
                $error("status expected %0d got %0d", want.status, got.status);
                errors++;
            end
            if (got.command !== want.command)
            begin
                $error("command expected %0d got %0d", want.command, got.command);
                errors++;
            end
            if (got.param_value !== want.param_value)
            begin
                $error("param_value expected %0d got %0d", want.param_value, got.param_value);
                errors++;
            end
            if (got.baud_word !== want.baud_word)
            begin
                $error("baud_word expected %h got %h", want.baud_word, got.baud_word);
                errors++;
            end
            if (got.text_start !== want.text_start)
            begin
                $error("text_start expected %0d got %0d", want.text_start, got.text_start);
                errors++;
            end
            if (got.text_count !== want.text_count)
            begin
                $error("text_count expected %0d got %0d", want.text_count, got.text_count);
                errors++;
            end
            if (got.payload_len !== want.payload_len)
            begin
                $error("payload_len expected %0d got %0d", want.payload_len, got.payload_len);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [3:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    dcfd_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    dcfd_pkg::out_t out_data;

    frame_result_board board;
    int send_gap_pct = 7;
    int recv_stall_pct = 75;
    int hold_left = 0;
    int sent_total = 0;
    int cycle_count = 0;
    logic [7:0] frame_bytes[$];

    display_command_frame_decoder #(.MAX_FRAME_LEN(MAX_LEN)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** display_command_frame_decoder: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_request(in_data);
        if (rst_n && out_valid && !out_stall)
            board.check_frame(out_data);
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [7:0] cmd_char(logic [4:0] code);
        if (code == dcfd_pkg::CMD_COLOR)
            return dcfd_pkg::RAW_DUAL;
        if (code >= dcfd_pkg::CMD_BAUD)
            return dcfd_pkg::RAW_BASE + 8'(code - dcfd_pkg::CMD_BAUD);
        return dcfd_pkg::CHAR_ZERO + 8'(code);
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{frame_byte: value, last_byte: is_last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_total++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic send_brace(input logic [7:0] op, input bit has_arg,
                              input logic [7:0] arg, input int text_n,
                              input logic [7:0] close);
        frame_bytes = '{dcfd_pkg::BRACE_OPEN, op};
        if (has_arg)
            frame_bytes.push_back(arg);
        for (int i = 0; i < text_n; i++)
            frame_bytes.push_back(8'($urandom_range(255)));
        frame_bytes.push_back(close);
        send_frame();
    endtask

    // Wait for every pending result, then let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_row(input logic [3:0] value);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_row(value);
    endtask

    task automatic random_frame();
        int pick;
        int text_n;
        logic [4:0] code;
        logic [7:0] op;
        logic [7:0] arg;
        logic [7:0] close;
        logic [15:0] word;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            frame_bytes = '{dcfd_pkg::HOST_START};
            frame_bytes.push_back(($urandom_range(99) < 85) ? dcfd_pkg::HOST_CMD :
                                  8'($urandom_range(255)));
            case ($urandom_range(2))
                0: frame_bytes.push_back(dcfd_pkg::HOST_QUERY);
                1: frame_bytes.push_back(dcfd_pkg::HOST_CLEAR);
                default: frame_bytes.push_back(8'($urandom_range(255)));
            endcase
            if ($urandom_range(99) < 8)
                void'(frame_bytes.pop_back());
            else if ($urandom_range(99) < 8)
                frame_bytes.push_back(8'($urandom_range(255)));
            send_frame();
        end
        else if (pick < 88)
        begin
            code = 5'($urandom_range(dcfd_pkg::CMD_INIT, dcfd_pkg::CMD_VERSION));
            op = ($urandom_range(99) < 6) ? 8'($urandom_range(255)) : cmd_char(code);
            case ($urandom_range(9))
                0, 1, 2, 3: arg = dcfd_pkg::CHAR_ZERO + 8'($urandom_range(9));
                4, 5, 6: arg = 8'($urandom_range(9));
                default: arg = 8'($urandom_range(255));
            endcase
            pick = $urandom_range(99);
            text_n = (pick < 45) ? 0 : (pick < 65) ? $urandom_range(1, 2) :
                     $urandom_range(0, 24);
            close = ($urandom_range(99) < 95) ? dcfd_pkg::BRACE_CLOSE :
                    8'($urandom_range(255));
            if (op == dcfd_pkg::RAW_BASE && $urandom_range(99) < 70)
            begin
                case ($urandom_range(2))
                    0: word = dcfd_pkg::BAUD_LOW;
                    1: word = dcfd_pkg::BAUD_HIGH;
                    default: word = 16'($urandom_range(65535));
                endcase
                if ($urandom_range(1))
                    arg = 8'($urandom_range(1));
                frame_bytes = '{dcfd_pkg::BRACE_OPEN, op, arg, word[15:8], word[7:0], close};
                send_frame();
            end
            else
                send_brace(op, $urandom_range(99) < 90, arg, text_n, close);
        end
        else
        begin
            frame_bytes = {};
            text_n = $urandom_range(1, 8);
            for (int i = 0; i < text_n; i++)
                frame_bytes.push_back(8'($urandom_range(255)));
            if ($urandom_range(99) < 20)
                frame_bytes[0] = dcfd_pkg::BRACE_OPEN;
            send_frame();
        end
    endtask

    initial
    begin
        logic [3:0] row_plan[6];
        logic [15:0] word;
        int phase_start;
        board = new();
        row_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'($urandom_range(2, 7)),
                     4'($urandom_range(15))};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // host frames: query, clear, bad parameter, short, long, lone byte
        frame_bytes = '{dcfd_pkg::HOST_START, dcfd_pkg::HOST_CMD, dcfd_pkg::HOST_QUERY};
        send_frame();
        frame_bytes = '{dcfd_pkg::HOST_START, dcfd_pkg::HOST_CMD, dcfd_pkg::HOST_CLEAR};
        send_frame();
        frame_bytes = '{dcfd_pkg::HOST_START, dcfd_pkg::HOST_CMD, 8'h00};
        send_frame();
        frame_bytes = '{dcfd_pkg::HOST_START, dcfd_pkg::HOST_CMD};
        send_frame();
        frame_bytes = '{dcfd_pkg::HOST_START, dcfd_pkg::HOST_CMD, dcfd_pkg::HOST_QUERY,
                        8'hFF};
        send_frame();
        frame_bytes = '{8'hFF};
        send_frame();
        // brace commands at the reset row limit
        send_brace(cmd_char(dcfd_pkg::CMD_INIT), 0, 8'h00, 0, dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_CHECK), 1, 8'h00, 0, dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_ERASE), 1, dcfd_pkg::CHAR_ONE, 1,
                   dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_LINE), 1, dcfd_pkg::CHAR_ONE, 3,
                   dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_LINE), 1, dcfd_pkg::CHAR_SEVEN, 0,
                   dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_FIXED), 1, dcfd_pkg::CHAR_ZERO, 11,
                   dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_FIXED), 1, dcfd_pkg::CHAR_ONE, 19,
                   dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_VOICE), 1, dcfd_pkg::CHAR_EIGHT, 0,
                   dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_VOICE), 1, dcfd_pkg::CHAR_EIGHT, 4,
                   dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_BRIGHT), 1, 8'd8, 0, dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_BRIGHT), 1, dcfd_pkg::CHAR_NINE, 0,
                   dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_VOLUME), 1, dcfd_pkg::CHAR_FIVE, 0,
                   dcfd_pkg::BRACE_CLOSE);
        // 0x41 by length: color, dot size, and neither
        send_brace(dcfd_pkg::RAW_DUAL, 1, dcfd_pkg::CHAR_THREE, 1, dcfd_pkg::BRACE_CLOSE);
        send_brace(dcfd_pkg::RAW_DUAL, 1, 8'd2, 0, dcfd_pkg::BRACE_CLOSE);
        send_brace(dcfd_pkg::RAW_DUAL, 0, 8'h00, 0, dcfd_pkg::BRACE_CLOSE);
        word = dcfd_pkg::BAUD_HIGH;
        frame_bytes = '{dcfd_pkg::BRACE_OPEN, dcfd_pkg::RAW_BASE, 8'h01, word[15:8],
                        word[7:0], dcfd_pkg::BRACE_CLOSE};
        send_frame();
        send_brace(cmd_char(dcfd_pkg::CMD_FONT), 1, 8'd3, 0, dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_PROTO), 1, 8'd3, 0, dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_VERSION), 0, 8'h00, 0, dcfd_pkg::BRACE_CLOSE);
        // unknown command, missing close, bad opener
        send_brace(8'h5A, 0, 8'h00, 0, dcfd_pkg::BRACE_CLOSE);
        send_brace(cmd_char(dcfd_pkg::CMD_INIT), 0, 8'h00, 0, 8'h00);
        frame_bytes = '{8'h58, dcfd_pkg::CHAR_ONE, dcfd_pkg::BRACE_CLOSE};
        send_frame();
        // over-long frame that also drives the byte count into saturation
        send_brace(cmd_char(dcfd_pkg::CMD_SCREEN), 0, 8'h00, MAX_LEN,
                   dcfd_pkg::BRACE_CLOSE);

        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            write_row(row_plan[phase]);
            send_gap_pct = (phase < 2) ? 7 : (phase < 4) ? 75 : 0;
            recv_stall_pct = (phase < 2) ? 75 : (phase < 4) ? 7 : 0;
            // back up the result side with short frames so the input has to stall
            if (phase == 4)
            begin
                hold_left = 80;
                for (int k = 0; k < 8; k++)
                    send_brace(cmd_char(dcfd_pkg::CMD_VERSION), 0, 8'h00, 0,
                               dcfd_pkg::BRACE_CLOSE);
            end
            phase_start = sent_total;
            while (sent_total - phase_start < PHASE_BYTES)
                random_frame();
        end
        drain();

        if (board.errors == 0)
            $display("** display_command_frame_decoder: PASSED **");
        else
            $display("** display_command_frame_decoder: FAILED **");
        $finish;
    end
endmodule

// File: filelist.f
sv/dcfd_pkg.sv
sv/dcfd_front.sv
sv/dcfd_queue.sv
sv/dcfd_back.sv
sv/display_command_frame_decoder.sv
bench/testbench.sv
